FILE: design/refc_pkg.sv
// Shared types and constants for the reference-counted entry cache.
// No dependencies; imported by every module of the block.
package refc_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int GRP_SIZE    = 8;
  localparam int LOC_W       = 3;
  localparam int SLOT_W      = 6;
  localparam int DEV_W       = 8;
  localparam int OBJ_W       = 16;
  localparam int REF_W       = 16;
  localparam int STAT_W      = 2;

  localparam logic [REF_W-1:0] REF_MAX = '1;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNREF = 2'd2;
  localparam logic [STAT_W-1:0] STAT_SAT   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_GRP,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic              cmd;
    logic [DEV_W-1:0]  dev;
    logic [OBJ_W-1:0]  obj;
    logic [SLOT_W-1:0] rel;
  } req_t;

  typedef struct packed {
    logic [REF_W-1:0] refs;
    logic             load_key;
    logic [DEV_W-1:0] dev;
    logic [OBJ_W-1:0] obj;
  } cwr_t;

  typedef struct packed {
    logic             hit_found;
    logic [LOC_W-1:0] hit_loc;
    logic             free_found;
    logic [LOC_W-1:0] free_loc;
    logic [REF_W-1:0] refs;
  } grp_t;

endpackage

FILE: design/refcounted_entry_cache_top.sv
// Reference-counted entry cache: get looks up or claims a slot, put
// releases a reference. Usage:
//   Input beat (in_valid/in_stall): in_cmd 0 = get with in_device_id and
//   in_object_number, 1 = put of in_release_slot.
//   Result beat (out_valid/out_stall): slot index, hit, load_needed,
//   write_back, count after the request and a status code.
//   Each request produces exactly one result beat. The result passes through
//   the cell row, which compares the key, the groups of eight cells, which
//   reduce, and the final stage, which picks the slot and updates it.
//   One request is in flight at a time and the idle state takes the next, so
//   a new request is accepted only after the previous one has been written
//   to the result register.
//   The output register holds a finished result while out_stall is high;
//   the next request may be accepted meanwhile, and it waits in its
//   update step until the result register is free.
//   Synchronous reset clears all counts (every slot free) and both
//   handshakes; slot keys are not cleared.
// Depends on refc_pkg, refc_cell and refc_group.
module refcounted_entry_cache_top #(
  parameter int ENTRIES = refc_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [refc_pkg::DEV_W-1:0]    in_device_id,
  input  logic [refc_pkg::OBJ_W-1:0]    in_object_number,
  input  logic [refc_pkg::SLOT_W-1:0]   in_release_slot,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [refc_pkg::SLOT_W-1:0]   out_slot_index,
  output logic                          out_hit,
  output logic                          out_load_needed,
  output logic                          out_write_back,
  output logic [refc_pkg::REF_W-1:0]    out_ref_after,
  output logic [refc_pkg::STAT_W-1:0]   out_status
);
  import refc_pkg::*;

  localparam int NGRP = (ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
  localparam int NPAD = NGRP * GRP_SIZE;
  localparam int TIW  = $clog2(NPAD);

  state_t state_r, state_nxt;
  req_t   req_r;

  logic [NPAD-1:0]            match_v;
  logic [NPAD-1:0]            free_v;
  logic [NPAD-1:0][REF_W-1:0] refm_v;
  grp_t                       grp_r [NGRP];

  logic             hit_any, free_any;
  logic [TIW-1:0]   hit_idx, free_idx;
  logic [REF_W-1:0] refs_sel;

  logic             go;
  logic             wr_en;
  logic [TIW-1:0]   wr_idx;
  cwr_t             wr;
  logic [NPAD-1:0]  wr_sel;

  logic              out_valid_r;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              hit_r, hit_nxt;
  logic              load_r, load_nxt;
  logic              wb_r, wb_nxt;
  logic [REF_W-1:0]  refa_r, refa_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;

  genvar gi;
  generate
    for (gi = 0; gi < NPAD; gi++) begin : g_cell
      if (gi < ENTRIES) begin : g_live
        assign wr_sel[gi] = wr_en && (wr_idx == TIW'(gi));
        refc_cell #(.IDX(gi)) u_cell (
          .clk     (clk),
          .rst_n   (rst_n),
          .req     (req_r),
          .wr_en   (wr_sel[gi]),
          .wr      (wr),
          .match_r (match_v[gi]),
          .free_r  (free_v[gi]),
          .refm_r  (refm_v[gi])
        );
      end else begin : g_pad
        assign wr_sel[gi]  = 1'b0;
        assign match_v[gi] = 1'b0;
        assign free_v[gi]  = 1'b0;
        assign refm_v[gi]  = '0;
      end
    end

    for (gi = 0; gi < NGRP; gi++) begin : g_grp
      refc_group u_grp (
        .clk   (clk),
        .match (match_v[gi*GRP_SIZE +: GRP_SIZE]),
        .free  (free_v[gi*GRP_SIZE +: GRP_SIZE]),
        .refm  (refm_v[gi*GRP_SIZE +: GRP_SIZE]),
        .res_r (grp_r[gi])
      );
    end
  endgenerate

  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    refs_sel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_r[g].hit_found) begin
        hit_any = 1'b1;
        hit_idx = TIW'(g * GRP_SIZE) | TIW'(grp_r[g].hit_loc);
      end
      if (grp_r[g].free_found) begin
        free_any = 1'b1;
        free_idx = TIW'(g * GRP_SIZE) | TIW'(grp_r[g].free_loc);
      end
      refs_sel = refs_sel | grp_r[g].refs;
    end
  end

  assign go = !out_valid_r || !out_stall;

  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = in_valid ? ST_CMP : ST_IDLE;
      ST_CMP:  state_nxt = ST_GRP;
      ST_GRP:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = go ? ST_IDLE : ST_UPD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    wr_en       = 1'b0;
    wr_idx      = hit_idx;
    wr.refs     = '0;
    wr.load_key = 1'b0;
    wr.dev      = req_r.dev;
    wr.obj      = req_r.obj;
    slot_nxt    = '0;
    hit_nxt     = 1'b0;
    load_nxt    = 1'b0;
    wb_nxt      = 1'b0;
    refa_nxt    = '0;
    stat_nxt    = STAT_OK;
    if (req_r.cmd == CMD_GET) begin
      if (hit_any) begin
        slot_nxt = SLOT_W'(hit_idx);
        hit_nxt  = 1'b1;
        if (refs_sel == REF_MAX) begin
          refa_nxt = REF_MAX;
          stat_nxt = STAT_SAT;
        end else begin
          wr_en    = 1'b1;
          wr.refs  = refs_sel + REF_W'(1);
          refa_nxt = refs_sel + REF_W'(1);
        end
      end else if (free_any) begin
        wr_en       = 1'b1;
        wr_idx      = free_idx;
        wr.refs     = REF_W'(1);
        wr.load_key = 1'b1;
        slot_nxt    = SLOT_W'(free_idx);
        load_nxt    = 1'b1;
        refa_nxt    = REF_W'(1);
      end else begin
        stat_nxt = STAT_FULL;
      end
    end else begin
      slot_nxt = req_r.rel;
      if (!hit_any || refs_sel == '0) begin
        stat_nxt = STAT_UNREF;
      end else begin
        wr_en    = 1'b1;
        wr.refs  = refs_sel - REF_W'(1);
        refa_nxt = refs_sel - REF_W'(1);
        wb_nxt   = (refs_sel == REF_W'(1));
      end
    end
    if (state_r != ST_UPD || !go) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_UPD && go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      req_r.cmd <= in_cmd;
      req_r.dev <= in_device_id;
      req_r.obj <= in_object_number;
      req_r.rel <= in_release_slot;
    end
    if (state_r == ST_UPD && go) begin
      slot_r <= slot_nxt;
      hit_r  <= hit_nxt;
      load_r <= load_nxt;
      wb_r   <= wb_nxt;
      refa_r <= refa_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slot_index  = slot_r;
  assign out_hit         = hit_r;
  assign out_load_needed = load_r;
  assign out_write_back  = wb_r;
  assign out_ref_after   = refa_r;
  assign out_status      = stat_r;

endmodule

FILE: design/refc_cell.sv
// One table slot: key, reference count and a registered compare result.
// Depends on refc_pkg.
module refc_cell #(
  parameter int IDX = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  refc_pkg::req_t                  req,
  input  logic                            wr_en,
  input  refc_pkg::cwr_t                  wr,
  output logic                            match_r,
  output logic                            free_r,
  output logic [refc_pkg::REF_W-1:0]      refm_r
);
  import refc_pkg::*;

  localparam bit IN_RANGE = (IDX < (1 << SLOT_W));

  logic [DEV_W-1:0] dev_r;
  logic [OBJ_W-1:0] obj_r;
  logic [REF_W-1:0] refs_r;
  logic             match_nxt;

  always_comb begin
    if (req.cmd == CMD_GET) begin
      match_nxt = (refs_r != '0) && (dev_r == req.dev) && (obj_r == req.obj);
    end else begin
      match_nxt = IN_RANGE && (req.rel == SLOT_W'(IDX));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refs_r <= '0;
    end else if (wr_en) begin
      refs_r <= wr.refs;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr.load_key) begin
      dev_r <= wr.dev;
      obj_r <= wr.obj;
    end
    match_r <= match_nxt;
    free_r  <= (refs_r == '0);
    refm_r  <= match_nxt ? refs_r : '0;
  end

endmodule

FILE: design/refc_group.sv
// Registered reduction over eight neighboring cells: lowest match,
// lowest free slot and the matched count. Depends on refc_pkg.
module refc_group (
  input  logic                                                  clk,
  input  logic [refc_pkg::GRP_SIZE-1:0]                         match,
  input  logic [refc_pkg::GRP_SIZE-1:0]                         free,
  input  logic [refc_pkg::GRP_SIZE-1:0][refc_pkg::REF_W-1:0]    refm,
  output refc_pkg::grp_t                                        res_r
);
  import refc_pkg::*;

  grp_t res_nxt;

  always_comb begin
    res_nxt = '0;
    for (int i = GRP_SIZE - 1; i >= 0; i--) begin
      if (match[i]) begin
        res_nxt.hit_found = 1'b1;
        res_nxt.hit_loc   = LOC_W'(i);
      end
      if (free[i]) begin
        res_nxt.free_found = 1'b1;
        res_nxt.free_loc   = LOC_W'(i);
      end
      res_nxt.refs = res_nxt.refs | refm[i];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for refcounted_entry_cache_top: get and put beats go in,
// a slot-table predictor in the bench works out each result beat, and a checker compares them.
// Depends on refc_pkg and the cache RTL.
module tb;
  import refc_pkg::*;

  localparam int NSLOT       = ENTRIES_DEF;
  localparam int POOL        = 96;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              load;
    logic              wb;
    logic [REF_W-1:0]  refs;
    logic [STAT_W-1:0] status;
  } outcome_t;

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              in_valid         = 1'b0;
  logic              in_stall;
  logic              in_cmd           = CMD_GET;
  logic [DEV_W-1:0]  in_device_id     = '0;
  logic [OBJ_W-1:0]  in_object_number = '0;
  logic [SLOT_W-1:0] in_release_slot  = '0;
  logic              out_valid;
  logic              out_stall        = 1'b0;
  logic [SLOT_W-1:0] out_slot_index;
  logic              out_hit;
  logic              out_load_needed;
  logic              out_write_back;
  logic [REF_W-1:0]  out_ref_after;
  logic [STAT_W-1:0] out_status;

  logic [DEV_W-1:0] key_dev [NSLOT];
  logic [OBJ_W-1:0] key_obj [NSLOT];
  logic [REF_W-1:0] ref_cnt [NSLOT];
  logic [DEV_W-1:0] pool_dev [POOL];
  logic [OBJ_W-1:0] pool_obj [POOL];

  outcome_t outcome_q[$];
  int       mismatch_cnt = 0;
  int       cycle_cnt    = 0;
  int       idle_pct     = 0;
  int       stall_pct    = 0;

  refcounted_entry_cache_top u_top (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic outcome_t cache_outcome(input logic cmd, input logic [DEV_W-1:0] dev,
                                             input logic [OBJ_W-1:0] obj,
                                             input logic [SLOT_W-1:0] rel);
    outcome_t r;
    int       i;
    int       free_at;
    r = '0;
    free_at = -1;
    if (cmd == CMD_GET) begin
      for (i = 0; i < NSLOT; i++) begin
        if (ref_cnt[i] != 0 && key_dev[i] == dev && key_obj[i] == obj) begin
          r.slot = SLOT_W'(i);
          r.hit  = 1'b1;
          if (ref_cnt[i] == REF_MAX) begin
            r.status = STAT_SAT;
          end else begin
            ref_cnt[i] = ref_cnt[i] + 1'b1;
            r.status = STAT_OK;
          end
          r.refs = ref_cnt[i];
          return r;
        end
        if (free_at < 0 && ref_cnt[i] == 0) free_at = i;
      end
      if (free_at < 0) begin
        r.status = STAT_FULL;
        return r;
      end
      key_dev[free_at] = dev;
      key_obj[free_at] = obj;
      ref_cnt[free_at] = REF_W'(1);
      r.slot   = SLOT_W'(free_at);
      r.load   = 1'b1;
      r.refs   = REF_W'(1);
      r.status = STAT_OK;
      return r;
    end
    r.slot = rel;
    if (int'(rel) >= NSLOT || ref_cnt[rel] == 0) begin
      r.status = STAT_UNREF;
      return r;
    end
    ref_cnt[rel] = ref_cnt[rel] - 1'b1;
    r.refs   = ref_cnt[rel];
    r.wb     = (ref_cnt[rel] == 0);
    r.status = STAT_OK;
    return r;
  endfunction

  task automatic note_error(input string what, input outcome_t want, input outcome_t got);
    if (mismatch_cnt < 10)
      $display("tb: %s exp slot=%0d hit=%0b load=%0b wb=%0b ref=%0d st=%0d | got slot=%0d hit=%0b load=%0b wb=%0b ref=%0d st=%0d",
               what, want.slot, want.hit, want.load, want.wb, want.refs, want.status,
               got.slot, got.hit, got.load, got.wb, got.refs, got.status);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    got = {out_slot_index, out_hit, out_load_needed, out_write_back, out_ref_after, out_status};
    if (rst_n && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        note_error("unexpected beat:", '0, got);
      end else begin
        want = outcome_q.pop_front();
        if (got.slot !== want.slot || got.hit !== want.hit || got.load !== want.load ||
            got.wb !== want.wb || got.refs !== want.refs || got.status !== want.status)
          note_error("mismatch:", want, got);
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_req(input logic cmd, input logic [DEV_W-1:0] dev,
                          input logic [OBJ_W-1:0] obj, input logic [SLOT_W-1:0] rel);
    bit gapped;
    gapped = 1'b0;
    while ($urandom_range(0, 99) < idle_pct) begin
      if (!gapped) in_valid <= 1'b0;
      gapped = 1'b1;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_device_id     <= dev;
    in_object_number <= obj;
    in_release_slot  <= rel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    outcome_q.push_back(cache_outcome(cmd, dev, obj, rel));
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  function automatic int free_count();
    int i;
    int n;
    n = 0;
    for (i = 0; i < NSLOT; i++)
      if (ref_cnt[i] == 0) n++;
    return n;
  endfunction

  task automatic fresh_key(output logic [DEV_W-1:0] d, output logic [OBJ_W-1:0] o);
    bit live;
    int i;
    do begin
      d = DEV_W'($urandom);
      o = OBJ_W'($urandom);
      live = 1'b0;
      for (i = 0; i < NSLOT; i++)
        if (ref_cnt[i] != 0 && key_dev[i] == d && key_obj[i] == o) live = 1'b1;
    end while (live);
  endtask

  task automatic test_basic();
    idle_pct  = 0;
    stall_pct = 0;
    send_req(CMD_GET, 8'h00, 16'h0000, 6'h00);
    send_req(CMD_GET, 8'hFF, 16'hFFFF, 6'h3F);
    send_req(CMD_GET, 8'h00, 16'h0000, 6'h00);
    send_req(CMD_GET, 8'h00, 16'h0001, 6'h00);  // same device, other object
    send_req(CMD_GET, 8'h01, 16'h0000, 6'h00);  // same object, other device
    send_req(CMD_GET, 8'hFF, 16'hFFFF, 6'h00);
    send_req(CMD_PUT, 8'hFF, 16'hFFFF, 6'd0);
    send_req(CMD_PUT, 8'h00, 16'h0000, 6'd0);   // drops to zero
    send_req(CMD_PUT, 8'h00, 16'h0000, 6'd0);   // already free
    send_req(CMD_PUT, 8'h00, 16'h0000, 6'h3F);  // never claimed
    send_req(CMD_GET, 8'hAA, 16'h5555, 6'h00);  // reuses lowest free
    send_req(CMD_PUT, 8'h00, 16'h0000, 6'd1);
    send_req(CMD_PUT, 8'h00, 16'h0000, 6'd1);
    send_req(CMD_GET, 8'hFF, 16'hFFFF, 6'h00);  // stale key, free slot: miss
    send_req(CMD_GET, 8'h55, 16'hAAAA, 6'h15);
  endtask

  task automatic test_table_full();
    logic [DEV_W-1:0] d;
    logic [OBJ_W-1:0] o;
    idle_pct  = 20;
    stall_pct = 20;
    while (free_count() != 0) begin
      fresh_key(d, o);
      send_req(CMD_GET, d, o, SLOT_W'($urandom));
    end
    fresh_key(d, o);
    send_req(CMD_GET, d, o, '0);
    send_req(CMD_GET, key_dev[5], key_obj[5], '0);
    while (ref_cnt[NSLOT-1] != 0) send_req(CMD_PUT, '0, '0, SLOT_W'(NSLOT - 1));
    fresh_key(d, o);
    send_req(CMD_GET, d, o, '0);
    fresh_key(d, o);
    send_req(CMD_GET, d, o, '0);
  endtask

  task automatic random_req(input int get_pct);
    int                i;
    int                k;
    logic [SLOT_W-1:0] rel;
    logic [SLOT_W-1:0] live[$];
    if ($urandom_range(0, 99) < 10) begin
      send_req(1'($urandom), DEV_W'($urandom), OBJ_W'($urandom), SLOT_W'($urandom));
    end else if ($urandom_range(0, 99) < get_pct) begin
      k = $urandom_range(0, POOL - 1);
      send_req(CMD_GET, pool_dev[k], pool_obj[k], SLOT_W'($urandom));
    end else begin
      for (i = 0; i < NSLOT; i++)
        if (ref_cnt[i] != 0) live.push_back(SLOT_W'(i));
      if (live.size() != 0 && $urandom_range(0, 99) < 85)
        rel = live[$urandom_range(0, live.size() - 1)];
      else
        rel = SLOT_W'($urandom);
      send_req(CMD_PUT, DEV_W'($urandom), OBJ_W'($urandom), rel);
    end
  endtask

  task automatic run_phase(input int n, input int get_pct, input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) random_req(get_pct);
  endtask

  task automatic test_random_traffic();
    int k;
    for (k = 0; k < POOL; k++) begin
      pool_dev[k] = (k % 2 == 1) ? pool_dev[k-1] : DEV_W'($urandom);
      pool_obj[k] = OBJ_W'($urandom);
    end
    pool_dev[0] = '0;
    pool_obj[0] = '0;
    pool_dev[2] = '1;
    pool_obj[2] = '1;
    run_phase(300, 40, 0, 0);
    run_phase(300, 60, 57, 0);
    run_phase(300, 45, 0, 57);
    run_phase(140, 55, 20, 20);
    wait_quiet();
    run_phase(140, 40, 20, 20);
  endtask

  task automatic test_release_all();
    int i;
    idle_pct  = 20;
    stall_pct = 57;
    for (i = 0; i < NSLOT; i++)
      while (ref_cnt[i] != 0)
        send_req(CMD_PUT, DEV_W'($urandom), OBJ_W'($urandom), SLOT_W'(i));
  endtask

  // one key climbs well above one, then steps back down
  task automatic test_count_climb();
    idle_pct  = 0;
    stall_pct = 0;
    repeat (40) send_req(CMD_GET, 8'h5A, 16'hA5C3, '0);
    repeat (3) send_req(CMD_PUT, '0, '0, 6'd0);
    send_req(CMD_GET, 8'h5A, 16'hA5C3, '0);
    send_req(CMD_GET, 8'h5A, 16'hA5C3, '0);
    send_req(CMD_PUT, '0, '0, 6'd0);
  endtask

  initial begin
    int i;
    for (i = 0; i < NSLOT; i++) begin
      key_dev[i] = '0;
      key_obj[i] = '0;
      ref_cnt[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_basic();
    test_table_full();
    test_random_traffic();
    test_release_all();
    test_count_climb();
    in_valid <= 1'b0;
    wait_quiet();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && outcome_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
design/refc_pkg.sv
design/refc_cell.sv
design/refc_group.sv
design/refcounted_entry_cache_top.sv
tb/tb.sv
